[sv/lss_pkg.sv]
// ----------------------------------------------------------------------------
// lss_pkg: shared types and constants for the last-substring search core
// Field widths, operation codes, default buffer depths and the result
// bundle passed from the search sequencer to the output stage.
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam int DEF_SOURCE_DEPTH  = 1024;
    localparam int DEF_PATTERN_DEPTH = 64;

    localparam int OP_W    = 2;
    localparam int POS_W   = 10;   // char_position
    localparam int BYTE_W  = 8;    // char_value
    localparam int LEN_W   = 11;   // source_length, match_position
    localparam int PLEN_W  = 7;    // pattern_length
    localparam int BOUND_W = 16;   // from_index

    localparam int S_DATA_W = 56;  // 52 bits of fields, padded to bytes
    localparam int M_DATA_W = 16;  // 11 bits of fields, padded to bytes

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_SOURCE  = 2'd0,
        OP_WRITE_PATTERN = 2'd1,
        OP_SEARCH        = 2'd2
    } op_t;

    typedef struct packed {
        logic              valid;
        logic              found;
        logic [LEN_W-1:0]  position;
    } lss_result_t;

    function automatic int addr_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

[sv/last_substring_search_core.sv]
// ----------------------------------------------------------------------------
// last_substring_search_core: last-occurrence substring search
// Source and pattern buffers written by byte, backward naive search.
// ----------------------------------------------------------------------------
// Byte writes (tuser 0 source, 1 pattern) may come back to back; writes past
// the buffer depth are dropped, code 3 is dropped. A search request (tuser 2)
// occupies the block until its result moves to the output register; each
// byte comparison reads both buffers through their single read ports, then
// uses the shared byte comparator. The input is not ready while a search runs.
// One result per search: tuser is found, tdata the last match start at or
// below min(from_index, source_length - pattern_length), zero when not found.
// Writes are taken while an earlier result still waits on the output.
module last_substring_search_core #(
    parameter int   SOURCE_DEPTH  = lss_pkg::DEF_SOURCE_DEPTH,
    parameter int   PATTERN_DEPTH = lss_pkg::DEF_PATTERN_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [9:0] char_position, [17:10] char_value, [28:18] source_length,
    // [35:29] pattern_length, [51:36] from_index
    input  logic [lss_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic [lss_pkg::OP_W-1:0]          s_tuser,   // [1:0] operation
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lss_pkg::M_DATA_W-1:0]      m_tdata,   // [10:0] match_position
    output logic                              m_tuser    // [0] found
);

    localparam int SRC_AW = lss_pkg::addr_width(SOURCE_DEPTH);
    localparam int PAT_AW = lss_pkg::addr_width(PATTERN_DEPTH);

    logic [lss_pkg::POS_W-1:0]    char_position;
    logic [lss_pkg::BYTE_W-1:0]   char_value;
    logic [lss_pkg::LEN_W-1:0]    source_length;
    logic [lss_pkg::PLEN_W-1:0]   pattern_length;
    logic [lss_pkg::BOUND_W-1:0]  from_index;
    lss_pkg::op_t                 operation;

    logic                         accept;
    logic                         src_we, pat_we, search_start;
    logic                         ctrl_idle;
    logic [lss_pkg::BYTE_W-1:0]   src_byte, pat_byte;
    logic [SRC_AW-1:0]            src_raddr;
    logic [PAT_AW-1:0]            pat_raddr;
    lss_pkg::lss_result_t         result;
    logic                         result_load;

    logic                         m_valid_reg;
    logic                         m_found_reg;
    logic [lss_pkg::LEN_W-1:0]    m_pos_reg;

    assign char_position  = s_tdata[9:0];
    assign char_value     = s_tdata[17:10];
    assign source_length  = s_tdata[28:18];
    assign pattern_length = s_tdata[35:29];
    assign from_index     = s_tdata[51:36];
    assign operation      = lss_pkg::op_t'(s_tuser);

    assign s_tready = ctrl_idle;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        src_we       = 1'b0;
        pat_we       = 1'b0;
        search_start = 1'b0;
        unique case (operation)
            lss_pkg::OP_WRITE_SOURCE:
                src_we = accept && (32'(char_position) < SOURCE_DEPTH);
            lss_pkg::OP_WRITE_PATTERN:
                pat_we = accept && (32'(char_position) < PATTERN_DEPTH);
            lss_pkg::OP_SEARCH:
                search_start = accept;
            default: ;
        endcase
    end

    lss_byte_ram #(.DEPTH(SOURCE_DEPTH)) u_source_ram (
        .aclk    (aclk),
        .wr_en   (src_we),
        .wr_addr (SRC_AW'(char_position)),
        .wr_data (char_value),
        .rd_addr (src_raddr),
        .rd_data (src_byte)
    );

    lss_byte_ram #(.DEPTH(PATTERN_DEPTH)) u_pattern_ram (
        .aclk    (aclk),
        .wr_en   (pat_we),
        .wr_addr (PAT_AW'(char_position)),
        .wr_data (char_value),
        .rd_addr (pat_raddr),
        .rd_data (pat_byte)
    );

    lss_search_ctrl #(
        .SOURCE_DEPTH  (SOURCE_DEPTH),
        .PATTERN_DEPTH (PATTERN_DEPTH)
    ) u_search_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (search_start),
        .source_length  (source_length),
        .pattern_length (pattern_length),
        .from_index     (from_index),
        .idle           (ctrl_idle),
        .src_byte       (src_byte),
        .pat_byte       (pat_byte),
        .src_raddr      (src_raddr),
        .pat_raddr      (pat_raddr),
        .result         (result),
        .result_ack     (result_load)
    );

    // result moves into the output register once the slot is free
    assign result_load = result.valid && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (result_load) begin
            m_found_reg <= result.found;
            m_pos_reg   <= result.position;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = lss_pkg::M_DATA_W'(m_pos_reg);

endmodule

[sv/lss_byte_ram.sv]
// ----------------------------------------------------------------------------
// lss_byte_ram: byte-wide buffer, one write and one read port
// Simple dual-port memory with registered read data.
// ----------------------------------------------------------------------------
module lss_byte_ram #(
    parameter int   DEPTH = lss_pkg::DEF_SOURCE_DEPTH,
    localparam int  AW    = lss_pkg::addr_width(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [lss_pkg::BYTE_W-1:0]  wr_data,
    input  logic [AW-1:0]               rd_addr,
    output logic [lss_pkg::BYTE_W-1:0]  rd_data
);

    logic [lss_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [lss_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/lss_search_ctrl.sv]
// ----------------------------------------------------------------------------
// lss_search_ctrl: search sequencer around one shared byte comparator
// Clamps the bound, then walks candidate starts from the clamped bound down
// to zero, comparing one pattern byte against one source byte per step,
// last pattern byte first.
// ----------------------------------------------------------------------------
module lss_search_ctrl #(
    parameter int   SOURCE_DEPTH  = lss_pkg::DEF_SOURCE_DEPTH,
    parameter int   PATTERN_DEPTH = lss_pkg::DEF_PATTERN_DEPTH,
    localparam int  SRC_AW        = lss_pkg::addr_width(SOURCE_DEPTH),
    localparam int  PAT_AW        = lss_pkg::addr_width(PATTERN_DEPTH)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [lss_pkg::LEN_W-1:0]     source_length,
    input  logic [lss_pkg::PLEN_W-1:0]    pattern_length,
    input  logic [lss_pkg::BOUND_W-1:0]   from_index,     // two's complement
    output logic                          idle,
    input  logic [lss_pkg::BYTE_W-1:0]    src_byte,
    input  logic [lss_pkg::BYTE_W-1:0]    pat_byte,
    output logic [SRC_AW-1:0]             src_raddr,
    output logic [PAT_AW-1:0]             pat_raddr,
    output lss_pkg::lss_result_t          result,
    input  logic                          result_ack
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SETUP = 5'b00010,
        ST_FETCH = 5'b00100,
        ST_CHECK = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic [lss_pkg::LEN_W-1:0]       sl_reg, sl_next;
    logic [lss_pkg::PLEN_W-1:0]      pl_reg, pl_next;
    logic [lss_pkg::BOUND_W-1:0]     fi_reg, fi_next;
    logic [lss_pkg::LEN_W-1:0]       start_reg, start_next;
    logic [lss_pkg::PLEN_W-1:0]      idx_reg, idx_next;
    logic                            found_reg, found_next;

    logic [lss_pkg::LEN_W-1:0]       pl_wide;
    logic [lss_pkg::LEN_W-1:0]       right;
    logic [lss_pkg::LEN_W-1:0]       bound;
    logic [lss_pkg::LEN_W-1:0]       src_pos;
    logic                            bytes_equal;

    assign pl_wide = lss_pkg::LEN_W'(pl_reg);
    assign right   = sl_reg - pl_wide;
    // bound only meaningful when from_index is non-negative and pl <= sl
    assign bound   = (lss_pkg::BOUND_W'(right) < fi_reg) ? right
                                                         : fi_reg[lss_pkg::LEN_W-1:0];

    assign src_pos     = start_reg + lss_pkg::LEN_W'(idx_reg);
    assign src_raddr   = SRC_AW'(src_pos);
    assign pat_raddr   = PAT_AW'(idx_reg);
    assign bytes_equal = (src_byte == pat_byte);

    always_comb begin
        state_next = state_reg;
        sl_next    = sl_reg;
        pl_next    = pl_reg;
        fi_next    = fi_reg;
        start_next = start_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    // lengths saturate at the buffer depths
                    sl_next = (32'(source_length) > SOURCE_DEPTH)
                            ? lss_pkg::LEN_W'(SOURCE_DEPTH) : source_length;
                    pl_next = (32'(pattern_length) > PATTERN_DEPTH)
                            ? lss_pkg::PLEN_W'(PATTERN_DEPTH) : pattern_length;
                    fi_next    = from_index;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                start_next = bound;
                idx_next   = pl_reg - 1'b1;
                if (fi_reg[lss_pkg::BOUND_W-1] || (pl_wide > sl_reg)) begin
                    found_next = 1'b0;
                    start_next = '0;
                    state_next = ST_DONE;
                end else if (pl_reg == '0) begin
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (bytes_equal) begin
                    if (idx_reg == '0) begin
                        found_next = 1'b1;
                        state_next = ST_DONE;
                    end else begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = ST_FETCH;
                    end
                end else if (start_reg == '0) begin
                    found_next = 1'b0;
                    state_next = ST_DONE;
                end else begin
                    start_next = start_reg - 1'b1;
                    idx_next   = pl_reg - 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_DONE: begin
                if (result_ack) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        sl_reg    <= sl_next;
        pl_reg    <= pl_next;
        fi_reg    <= fi_next;
        start_reg <= start_next;
        idx_reg   <= idx_next;
        found_reg <= found_next;
    end

    assign idle            = (state_reg == ST_IDLE);
    assign result.valid    = (state_reg == ST_DONE);
    assign result.found    = found_reg;
    assign result.position = found_reg ? start_reg : '0;

endmodule
